### hw/rtl/gtg_pkg.sv
// Shared types and constants for the go-to-goal proportional controller.
// No dependencies; imported by every module of the block.
package gtg_pkg;

    localparam int POSE_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DIFF_W      = 17;
    localparam int SQ_W        = 34;
    localparam int TOL_SQ_W    = 32;
    localparam int ROOT_W      = 17;
    localparam int REM_W       = 18;
    localparam int SQRT_STEPS  = 17;
    localparam int XY_W        = 36;
    localparam int FRAC_W      = 16;
    localparam int Z_W         = 24;
    localparam int ATAN_N      = 24;
    localparam int ZH_W        = 32;
    localparam int ANG_FRAC    = 20;
    localparam int BH_W        = 12;
    localparam int ERR_W       = 18;
    localparam int GAIN_FRAC   = 8;
    localparam int LIN_PROD_W  = 33;
    localparam int ANG_PROD_W  = 35;
    localparam int LIN_W       = 31;
    localparam int ANG_W       = 32;

    // pi in units of 2^-20 rad
    localparam logic signed [Z_W-1:0]  PI_FINE   = 24'sd3294199;
    localparam logic signed [ZH_W-1:0] BH_SCALE  = 32'sd100;
    localparam logic signed [ZH_W-1:0] BH_HALF   = 32'sd524288;

    // atan(2^-i) in units of 2^-20 rad
    localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_N] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32,
        24'sd16,     24'sd8,      24'sd4,      24'sd2,
        24'sd1,      24'sd0,      24'sd0,      24'sd0
    };

    localparam logic [CFG_W-1:0] TOL_RST    = 16'd10;
    localparam logic [CFG_W-1:0] KP_LIN_RST = 16'd128;
    localparam logic [CFG_W-1:0] KP_ANG_RST = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X = 3'd0,
        REG_GOAL_Y = 3'd1,
        REG_TOL    = 3'd2,
        REG_KP_LIN = 3'd3,
        REG_KP_ANG = 3'd4
    } gtg_reg_idx_t;

    // Data carried down the cell chain: CORDIC vector and angle, square-root
    // radicand/root/remainder, and sideband for the back end.
    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic [SQ_W-1:0]          s_sh;
        logic [ROOT_W-1:0]        root;
        logic [REM_W-1:0]         rem;
        logic                     zero;
        logic                     arrived;
        logic signed [POSE_W-1:0] heading;
    } gtg_cell_t;

endpackage

### hw/rtl/gtg_front.sv
// Front end: goal offset, squared distance, arrival test and CORDIC pre-rotation.
// Depends on gtg_pkg.
module gtg_front
    import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pose_valid,
    output logic                     pose_ready,
    input  logic signed [POSE_W-1:0] pose_x,
    input  logic signed [POSE_W-1:0] pose_y,
    input  logic signed [POSE_W-1:0] pose_heading,
    input  logic signed [CFG_W-1:0]  goal_x,
    input  logic signed [CFG_W-1:0]  goal_y,
    input  logic [CFG_W-1:0]         arrive_tolerance,
    output logic                     out_valid,
    input  logic                     out_ready,
    output gtg_cell_t                out_cell
);

    logic                     a_valid_reg;
    logic                     a_ready;
    logic signed [DIFF_W-1:0] dx_a_reg;
    logic signed [DIFF_W-1:0] dy_a_reg;
    logic signed [POSE_W-1:0] head_a_reg;
    logic signed [DIFF_W-1:0] dx_a_next;
    logic signed [DIFF_W-1:0] dy_a_next;

    logic                     b_valid_reg;
    logic                     b_ready;
    logic signed [DIFF_W-1:0] dx_b_reg;
    logic signed [DIFF_W-1:0] dy_b_reg;
    logic signed [POSE_W-1:0] head_b_reg;
    logic [SQ_W-1:0]          dx_sq_reg;
    logic [SQ_W-1:0]          dy_sq_reg;
    logic [TOL_SQ_W-1:0]      tol_sq_reg;
    logic signed [SQ_W-1:0]   dx_sq_next;
    logic signed [SQ_W-1:0]   dy_sq_next;
    logic [TOL_SQ_W-1:0]      tol_sq_next;

    logic                     c_valid_reg;
    logic                     c_ready;
    gtg_cell_t                cell_reg;
    gtg_cell_t                cell_next;
    logic [SQ_W-1:0]          dist_sq;
    logic                     neg;
    logic signed [DIFF_W-1:0] dx_rot;
    logic signed [DIFF_W-1:0] dy_rot;

    assign c_ready    = !c_valid_reg || out_ready;
    assign b_ready    = !b_valid_reg || c_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign pose_ready = a_ready;
    assign out_valid  = c_valid_reg;
    assign out_cell   = cell_reg;

    assign dx_a_next   = DIFF_W'(goal_x) - DIFF_W'(pose_x);
    assign dy_a_next   = DIFF_W'(goal_y) - DIFF_W'(pose_y);
    assign dx_sq_next  = dx_a_reg * dx_a_reg;
    assign dy_sq_next  = dy_a_reg * dy_a_reg;
    assign tol_sq_next = arrive_tolerance * arrive_tolerance;

    always_comb
    begin
        dist_sq = dx_sq_reg + dy_sq_reg;
        neg     = dx_b_reg[DIFF_W-1];
        dx_rot  = neg ? -dx_b_reg : dx_b_reg;
        dy_rot  = neg ? -dy_b_reg : dy_b_reg;

        cell_next.x = XY_W'(dx_rot) <<< FRAC_W;
        cell_next.y = XY_W'(dy_rot) <<< FRAC_W;
        // left half-plane: start from +pi or -pi after negating the vector
        if (!neg)
        begin
            cell_next.z = '0;
        end
        else if (!dy_b_reg[DIFF_W-1])
        begin
            cell_next.z = PI_FINE;
        end
        else
        begin
            cell_next.z = -PI_FINE;
        end
        cell_next.s_sh    = dist_sq;
        cell_next.root    = '0;
        cell_next.rem     = '0;
        cell_next.zero    = (dx_b_reg == '0) && (dy_b_reg == '0);
        cell_next.arrived = dist_sq < SQ_W'(tol_sq_reg);
        cell_next.heading = head_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= pose_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && pose_valid)
        begin
            dx_a_reg   <= dx_a_next;
            dy_a_reg   <= dy_a_next;
            head_a_reg <= pose_heading;
        end
        if (b_ready && a_valid_reg)
        begin
            dx_b_reg   <= dx_a_reg;
            dy_b_reg   <= dy_a_reg;
            head_b_reg <= head_a_reg;
            dx_sq_reg  <= $unsigned(dx_sq_next);
            dy_sq_reg  <= $unsigned(dy_sq_next);
            tol_sq_reg <= tol_sq_next;
        end
        if (c_ready && b_valid_reg)
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

### hw/rtl/gtg_cell.sv
// One cell: a vectoring CORDIC rotation and a square-root digit, each optional.
// Depends on gtg_pkg.
module gtg_cell
    import gtg_pkg::*;
#(
    parameter int IDX     = 0,
    parameter bit ROT_EN  = 1'b1,
    parameter bit SQRT_EN = 1'b1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gtg_cell_t in_cell,
    output logic      out_valid,
    input  logic      out_ready,
    output gtg_cell_t out_cell
);

    logic                   valid_reg;
    gtg_cell_t              cell_reg;
    gtg_cell_t              cell_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic [REM_W+1:0]       trial_rem;
    logic [REM_W+1:0]       trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

    always_comb
    begin
        cell_next = in_cell;
        xs        = in_cell.x >>> IDX;
        ys        = in_cell.y >>> IDX;
        trial_rem = {in_cell.rem, in_cell.s_sh[SQ_W-1 -: 2]};
        trial     = {1'b0, in_cell.root, 2'b01};

        if (ROT_EN)
        begin
            if (in_cell.y > 0)
            begin
                cell_next.x = in_cell.x + ys;
                cell_next.y = in_cell.y - xs;
                cell_next.z = in_cell.z + ATAN_TAB[IDX];
            end
            else
            begin
                cell_next.x = in_cell.x - ys;
                cell_next.y = in_cell.y + xs;
                cell_next.z = in_cell.z - ATAN_TAB[IDX];
            end
        end

        // restoring square root, two radicand bits per cell
        if (SQRT_EN)
        begin
            cell_next.s_sh = in_cell.s_sh << 2;
            if (trial_rem >= trial)
            begin
                cell_next.rem  = REM_W'(trial_rem - trial);
                cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                cell_next.rem  = trial_rem[REM_W-1:0];
                cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

### hw/rtl/gtg_back.sv
// Back end: distance rounding, bearing scaling, gain products and command register.
// Depends on gtg_pkg.
module gtg_back
    import gtg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  gtg_cell_t               in_cell,
    input  logic [CFG_W-1:0]        kp_linear,
    input  logic [CFG_W-1:0]        kp_angular,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output logic [LIN_W-1:0]        linear_cmd,
    output logic signed [ANG_W-1:0] angular_cmd,
    output logic                    arrived
);

    // stage d: rounded distance, bearing in hundredths
    logic                         d_valid_reg;
    logic                         d_ready;
    logic [ROOT_W-1:0]            r_d_reg;
    logic signed [BH_W-1:0]       bh_d_reg;
    logic signed [POSE_W-1:0]     head_d_reg;
    logic                         arr_d_reg;
    logic signed [ZH_W-1:0]       z_scaled;
    logic signed [ZH_W-1:0]       z_round;
    logic [ROOT_W-1:0]            r_d_next;
    logic signed [BH_W-1:0]       bh_d_next;

    // stage e: angle error
    logic                         e_valid_reg;
    logic                         e_ready;
    logic [ROOT_W-1:0]            r_e_reg;
    logic signed [ERR_W-1:0]      err_e_reg;
    logic                         arr_e_reg;
    logic signed [ERR_W-1:0]      err_e_next;

    // stage f: gain products
    logic                         f_valid_reg;
    logic                         f_ready;
    logic [LIN_PROD_W-1:0]        lin_prod_reg;
    logic signed [ANG_PROD_W-1:0] ang_prod_reg;
    logic                         arr_f_reg;
    logic signed [CFG_W:0]        kpa_s;
    logic [LIN_PROD_W-1:0]        lin_prod_next;
    logic signed [ANG_PROD_W-1:0] ang_prod_next;

    // stage g: command register
    logic                         g_valid_reg;
    logic                         g_ready;
    logic [LIN_W-1:0]             linear_cmd_reg;
    logic signed [ANG_W-1:0]      angular_cmd_reg;
    logic                         arrived_reg;
    logic [LIN_W-1:0]             linear_cmd_next;
    logic signed [ANG_W-1:0]      angular_cmd_next;

    assign g_ready     = !g_valid_reg || cmd_ready;
    assign f_ready     = !f_valid_reg || g_ready;
    assign e_ready     = !e_valid_reg || f_ready;
    assign d_ready     = !d_valid_reg || e_ready;
    assign in_ready    = d_ready;
    assign cmd_valid   = g_valid_reg;
    assign linear_cmd  = linear_cmd_reg;
    assign angular_cmd = angular_cmd_reg;
    assign arrived     = arrived_reg;

    always_comb
    begin
        // round to nearest: remainder above root means the upper integer is closer
        r_d_next  = in_cell.root + ROOT_W'(in_cell.rem > REM_W'(in_cell.root));
        z_scaled  = ZH_W'(in_cell.z) * BH_SCALE;
        z_round   = z_scaled + BH_HALF;
        bh_d_next = in_cell.zero ? '0 : BH_W'(z_round >>> ANG_FRAC);
    end

    assign err_e_next    = ERR_W'(bh_d_reg) - ERR_W'(head_d_reg);
    assign kpa_s         = {1'b0, kp_angular};
    assign lin_prod_next = LIN_PROD_W'(kp_linear) * LIN_PROD_W'(r_e_reg);
    assign ang_prod_next = ANG_PROD_W'(kpa_s) * ANG_PROD_W'(err_e_reg);

    // Input ranges keep both shifted products far inside the command widths,
    // so truncating them to those widths loses no bits.
    always_comb
    begin
        if (arr_f_reg)
        begin
            linear_cmd_next  = '0;
            angular_cmd_next = '0;
        end
        else
        begin
            linear_cmd_next  = LIN_W'(lin_prod_reg >> GAIN_FRAC);
            angular_cmd_next = ANG_W'(ang_prod_reg >>> GAIN_FRAC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_valid_reg <= in_valid;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
            if (g_ready)
            begin
                g_valid_reg <= f_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && in_valid)
        begin
            r_d_reg    <= r_d_next;
            bh_d_reg   <= bh_d_next;
            head_d_reg <= in_cell.heading;
            arr_d_reg  <= in_cell.arrived;
        end
        if (e_ready && d_valid_reg)
        begin
            r_e_reg   <= r_d_reg;
            err_e_reg <= err_e_next;
            arr_e_reg <= arr_d_reg;
        end
        if (f_ready && e_valid_reg)
        begin
            lin_prod_reg <= lin_prod_next;
            ang_prod_reg <= ang_prod_next;
            arr_f_reg    <= arr_e_reg;
        end
        if (g_ready && f_valid_reg)
        begin
            linear_cmd_reg  <= linear_cmd_next;
            angular_cmd_reg <= angular_cmd_next;
            arrived_reg     <= arr_f_reg;
        end
    end

endmodule

### hw/rtl/go_to_goal_p_controller.sv
// Top level of the go-to-goal proportional controller: config registers and cell chain.
// Depends on gtg_pkg, gtg_front, gtg_cell, gtg_back.
//
//  channel   direction  handshake               payload
//  pose      in         pose_valid/pose_ready   pose_x, pose_y, pose_heading
//  cmd       out        cmd_valid/cmd_ready     linear_cmd, angular_cmd, arrived
//  config    in         cfg_write               cfg_index, cfg_data
//
// One item per cycle sustained while cmd_ready stays high. The path runs through
// three front stages, one cell per step of the longer of the CORDIC and the
// 17-digit square root, and four back stages.
// Every stage has its own valid bit; a stalled cmd channel fills bubbles first.
// Reset clears all valid bits and loads the config defaults.
module go_to_goal_p_controller
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pose_valid,
    output logic                     pose_ready,
    input  logic signed [POSE_W-1:0] pose_x,
    input  logic signed [POSE_W-1:0] pose_y,
    input  logic signed [POSE_W-1:0] pose_heading,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output logic [LIN_W-1:0]         linear_cmd,
    output logic signed [ANG_W-1:0]  angular_cmd,
    output logic                     arrived,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int CHAIN_LEN = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    logic signed [CFG_W-1:0] goal_x_reg;
    logic signed [CFG_W-1:0] goal_y_reg;
    logic [CFG_W-1:0]        tol_reg;
    logic [CFG_W-1:0]        kp_lin_reg;
    logic [CFG_W-1:0]        kp_ang_reg;

    gtg_cell_t chain_cell  [CHAIN_LEN+1];
    logic      chain_valid [CHAIN_LEN+1];
    logic      chain_ready [CHAIN_LEN+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            tol_reg    <= TOL_RST;
            kp_lin_reg <= KP_LIN_RST;
            kp_ang_reg <= KP_ANG_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GOAL_X: goal_x_reg <= cfg_data;
                REG_GOAL_Y: goal_y_reg <= cfg_data;
                REG_TOL:    tol_reg    <= cfg_data;
                REG_KP_LIN: kp_lin_reg <= cfg_data;
                REG_KP_ANG: kp_ang_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    gtg_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .pose_valid       (pose_valid),
        .pose_ready       (pose_ready),
        .pose_x           (pose_x),
        .pose_y           (pose_y),
        .pose_heading     (pose_heading),
        .goal_x           (goal_x_reg),
        .goal_y           (goal_y_reg),
        .arrive_tolerance (tol_reg),
        .out_valid        (chain_valid[0]),
        .out_ready        (chain_ready[0]),
        .out_cell         (chain_cell[0])
    );

    for (genvar i = 0; i < CHAIN_LEN; i++)
    begin : g_chain
        gtg_cell #(
            .IDX     (i),
            .ROT_EN  (i < CORDIC_STAGES),
            .SQRT_EN (i < SQRT_STEPS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    gtg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_valid[CHAIN_LEN]),
        .in_ready    (chain_ready[CHAIN_LEN]),
        .in_cell     (chain_cell[CHAIN_LEN]),
        .kp_linear   (kp_lin_reg),
        .kp_angular  (kp_ang_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .linear_cmd  (linear_cmd),
        .angular_cmd (angular_cmd),
        .arrived     (arrived)
    );

    // square-root remainder never exceeds twice the root
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[CHAIN_LEN] |->
            chain_cell[CHAIN_LEN].rem <= {chain_cell[CHAIN_LEN].root, 1'b0})
        else $error("square root remainder out of range");

    // vectoring keeps x in the right half-plane after pre-rotation
    a_cordic_x: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[CHAIN_LEN] |-> chain_cell[CHAIN_LEN].x >= 0)
        else $error("CORDIC x went negative");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[CHAIN_LEN] && chain_cell[CHAIN_LEN].zero |->
            chain_cell[CHAIN_LEN].x == '0 && chain_cell[CHAIN_LEN].y == '0)
        else $error("zero offset produced nonzero CORDIC vector");

    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && arrived |-> linear_cmd == '0 && angular_cmd == '0)
        else $error("commands not zero on arrival");

endmodule
